[src/rap_pkg.sv]
package rap_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int NUM_AXES        = 3;
  localparam int CORDIC_STEPS    = 24;
  localparam int CS_W            = 32;
  localparam int Z_W             = 33;
  localparam int ROT_MARGIN      = 4;
  localparam int FRAC_BITS       = 30;

  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [Z_W-1:0]  QTR_TURN    = 33'sd1073741824;
  localparam logic signed [Z_W-1:0]  HALF_TURN   = 33'sd2147483648;

  typedef logic signed [CS_W-1:0] cs_t;

  localparam cs_t TURN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // fold, cordic steps, sign fix
  localparam int CORDIC_STAGES = CORDIC_STEPS + 2;
  // two stages per axis plus output
  localparam int NUM_STAGES    = CORDIC_STAGES + 2 * NUM_AXES + 1;

endpackage

[src/rap_in_if.sv]
interface rap_in_if import rap_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  logic signed [COORD_WIDTH-1:0] pivot_x;
  logic signed [COORD_WIDTH-1:0] pivot_y;
  logic signed [COORD_WIDTH-1:0] pivot_z;
  logic [ANGLE_WIDTH-1:0]        angle_x;
  logic [ANGLE_WIDTH-1:0]        angle_y;
  logic [ANGLE_WIDTH-1:0]        angle_z;

  modport source (
    output valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
    output angle_x, angle_y, angle_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
    input  angle_x, angle_y, angle_z,
    output ready
  );
endinterface

[src/rap_out_if.sv]
interface rap_out_if import rap_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

[src/euler_rotate_about_pivot_3d_unit.sv]
// Euler X-Y-Z rotation of a point about a pivot, Q16.16 coordinates.
// in_chan (valid/ready) carries a point, a pivot and three binary angles
// (2^ANGLE_WIDTH is a full turn); out_chan gives the rotated point, each
// coordinate saturated to the signed COORD_WIDTH range.
// One request is accepted per cycle and one result leaves per cycle while
// no stall holds the pipeline. The stages are one range-fold stage, 24
// CORDIC stages, one sign stage, two stages (multiply, round and sum) per
// axis and one output stage. The CORDIC stage count sets most of the latency.
// Each stage has its own valid bit and advances when the next stage is
// empty or moving, so bubbles close up and a request is still accepted
// while a finished result waits on a stalled receiver. in_chan.ready drops
// only when every stage holds a request and out_chan.ready is low.
// Nothing is lost or repeated under stall.
// Reset clears all valid bits; the data registers are not reset.
module euler_rotate_about_pivot_3d_unit import rap_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  rap_in_if.sink   in_chan,
  rap_out_if.source out_chan
);

  localparam int CW = COORD_WIDTH;
  localparam int D  = CW + 1;
  localparam int RW = CW + ROT_MARGIN;
  localparam int NS = NUM_STAGES;
  localparam int PASS_C = 3 * D + 3 * CW;
  localparam int PASS_X = D + 3 * CW + 4 * CS_W;
  localparam int PASS_Y = RW + 3 * CW + 2 * CS_W;
  localparam int PASS_Z = RW + 3 * CW;
  localparam int ST_X = CORDIC_STAGES;
  localparam int ST_Y = CORDIC_STAGES + 2;
  localparam int ST_Z = CORDIC_STAGES + 4;

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_chan.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_chan.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_chan.ready = en[0];

  // pivot-relative point
  logic signed [D-1:0] dx, dy, dz;
  assign dx = D'(in_chan.point_x) - D'(in_chan.pivot_x);
  assign dy = D'(in_chan.point_y) - D'(in_chan.pivot_y);
  assign dz = D'(in_chan.point_z) - D'(in_chan.pivot_z);

  logic [ANGLE_WIDTH-1:0] ang [NUM_AXES];
  cs_t                    cos_v [NUM_AXES];
  cs_t                    sin_v [NUM_AXES];
  logic [PASS_C-1:0]      pass_c_i, pass_c_o;

  assign ang[0]   = in_chan.angle_x;
  assign ang[1]   = in_chan.angle_y;
  assign ang[2]   = in_chan.angle_z;
  assign pass_c_i = {dx, dy, dz, in_chan.pivot_x, in_chan.pivot_y, in_chan.pivot_z};

  rap_cordic #(
    .ANGLE_WIDTH(ANGLE_WIDTH),
    .PASS_W     (PASS_C)
  ) u_cordic (
    .clk   (clk),
    .en    (en[CORDIC_STAGES-1:0]),
    .ang_i (ang),
    .pass_i(pass_c_i),
    .cos_o (cos_v),
    .sin_o (sin_v),
    .pass_o(pass_c_o)
  );

  logic signed [D-1:0]  cx, cy, cz;
  logic signed [CW-1:0] px_c, py_c, pz_c;
  assign {cx, cy, cz, px_c, py_c, pz_c} = pass_c_o;

  // about x
  logic [PASS_X-1:0]    pass_x_i, pass_x_o;
  logic signed [RW-1:0] y_x, z_x;
  logic signed [D-1:0]  xx;
  logic signed [CW-1:0] px_x, py_x, pz_x;
  cs_t                  c1_x, s1_x, c2_x, s2_x;

  assign pass_x_i = {cx, px_c, py_c, pz_c, cos_v[1], sin_v[1], cos_v[2], sin_v[2]};

  rap_rot #(.RW(RW), .PASS_W(PASS_X)) u_rot_x (
    .clk   (clk),
    .en    (en[ST_X+1:ST_X]),
    .a_i   (RW'(cy)),
    .b_i   (RW'(cz)),
    .c_i   (cos_v[0]),
    .s_i   (sin_v[0]),
    .pass_i(pass_x_i),
    .a_o   (y_x),
    .b_o   (z_x),
    .pass_o(pass_x_o)
  );

  assign {xx, px_x, py_x, pz_x, c1_x, s1_x, c2_x, s2_x} = pass_x_o;

  // about y: a = z, b = x
  logic [PASS_Y-1:0]    pass_y_i, pass_y_o;
  logic signed [RW-1:0] z_y, x_y, y_y;
  logic signed [CW-1:0] px_y, py_y, pz_y;
  cs_t                  c2_y, s2_y;

  assign pass_y_i = {y_x, px_x, py_x, pz_x, c2_x, s2_x};

  rap_rot #(.RW(RW), .PASS_W(PASS_Y)) u_rot_y (
    .clk   (clk),
    .en    (en[ST_Y+1:ST_Y]),
    .a_i   (z_x),
    .b_i   (RW'(xx)),
    .c_i   (c1_x),
    .s_i   (s1_x),
    .pass_i(pass_y_i),
    .a_o   (z_y),
    .b_o   (x_y),
    .pass_o(pass_y_o)
  );

  assign {y_y, px_y, py_y, pz_y, c2_y, s2_y} = pass_y_o;

  // about z
  logic [PASS_Z-1:0]    pass_z_i, pass_z_o;
  logic signed [RW-1:0] x_z, y_z, z_z;
  logic signed [CW-1:0] px_z, py_z, pz_z;

  assign pass_z_i = {z_y, px_y, py_y, pz_y};

  rap_rot #(.RW(RW), .PASS_W(PASS_Z)) u_rot_z (
    .clk   (clk),
    .en    (en[ST_Z+1:ST_Z]),
    .a_i   (x_y),
    .b_i   (y_y),
    .c_i   (c2_y),
    .s_i   (s2_y),
    .pass_i(pass_z_i),
    .a_o   (x_z),
    .b_o   (y_z),
    .pass_o(pass_z_o)
  );

  assign {z_z, px_z, py_z, pz_z} = pass_z_o;

  // restore pivot and saturate
  localparam logic signed [RW:0] SAT_HI = {{(RW - CW + 2){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [RW:0] SAT_LO = {{(RW - CW + 2){1'b1}}, {(CW - 1){1'b0}}};

  logic signed [RW:0]   sx, sy, sz;
  logic signed [CW-1:0] ox_nxt, oy_nxt, oz_nxt;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;

  always_comb begin
    sx = (RW + 1)'(x_z) + (RW + 1)'(px_z);
    sy = (RW + 1)'(y_z) + (RW + 1)'(py_z);
    sz = (RW + 1)'(z_z) + (RW + 1)'(pz_z);
    ox_nxt = (sx > SAT_HI) ? SAT_HI[CW-1:0] : ((sx < SAT_LO) ? SAT_LO[CW-1:0] : sx[CW-1:0]);
    oy_nxt = (sy > SAT_HI) ? SAT_HI[CW-1:0] : ((sy < SAT_LO) ? SAT_LO[CW-1:0] : sy[CW-1:0]);
    oz_nxt = (sz > SAT_HI) ? SAT_HI[CW-1:0] : ((sz < SAT_LO) ? SAT_LO[CW-1:0] : sz[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_x_r <= ox_nxt;
      out_y_r <= oy_nxt;
      out_z_r <= oz_nxt;
    end
  end

  assign out_chan.valid = v_r[NS-1];
  assign out_chan.out_x = out_x_r;
  assign out_chan.out_y = out_y_r;
  assign out_chan.out_z = out_z_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v_r[0])
    else $error("accepted request did not enter the first stage");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (&v_r) && !out_chan.ready)
    else $error("input stalled with room in the pipeline");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=> out_chan.valid && $stable(out_x_r))
    else $error("waiting result changed or dropped");

endmodule

[src/rap_cordic.sv]
module rap_cordic import rap_pkg::*; #(
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int PASS_W      = 1
) (
  input  logic                   clk,
  input  logic [CORDIC_STAGES-1:0] en,
  input  logic [ANGLE_WIDTH-1:0] ang_i [NUM_AXES],
  input  logic [PASS_W-1:0]      pass_i,
  output cs_t                    cos_o [NUM_AXES],
  output cs_t                    sin_o [NUM_AXES],
  output logic [PASS_W-1:0]      pass_o
);

  cs_t                  x_r    [CORDIC_STEPS+1][NUM_AXES];
  cs_t                  y_r    [CORDIC_STEPS+1][NUM_AXES];
  logic signed [Z_W-1:0] z_r   [CORDIC_STEPS+1][NUM_AXES];
  logic                 flip_r [CORDIC_STEPS+1][NUM_AXES];
  logic [PASS_W-1:0]    pass_r [CORDIC_STAGES];
  cs_t                  cos_r  [NUM_AXES];
  cs_t                  sin_r  [NUM_AXES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pass_r[0] <= pass_i;
    end
  end

  for (genvar k = 1; k < CORDIC_STAGES; k++) begin : g_pass
    always_ff @(posedge clk) begin
      if (en[k]) begin
        pass_r[k] <= pass_r[k-1];
      end
    end
  end

  for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
    logic signed [31:0]    a32;
    logic signed [Z_W-1:0] z0;
    logic signed [Z_W-1:0] z_fold;
    logic                  f_fold;

    // range fold into [-quarter, quarter] turn
    always_comb begin
      a32    = $signed({ang_i[l], {(32-ANGLE_WIDTH){1'b0}}});
      z0     = Z_W'(a32);
      z_fold = z0;
      f_fold = 1'b0;
      if (z0 > QTR_TURN) begin
        z_fold = z0 - HALF_TURN;
        f_fold = 1'b1;
      end else if (z0 < -QTR_TURN) begin
        z_fold = z0 + HALF_TURN;
        f_fold = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        x_r[0][l]    <= CORDIC_GAIN;
        y_r[0][l]    <= '0;
        z_r[0][l]    <= z_fold;
        flip_r[0][l] <= f_fold;
      end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clk) begin
        if (en[i+1]) begin
          flip_r[i+1][l] <= flip_r[i][l];
          if (!z_r[i][l][Z_W-1]) begin
            x_r[i+1][l] <= x_r[i][l] - (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] + (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] - Z_W'(TURN_TAB[i]);
          end else begin
            x_r[i+1][l] <= x_r[i][l] + (y_r[i][l] >>> i);
            y_r[i+1][l] <= y_r[i][l] - (x_r[i][l] >>> i);
            z_r[i+1][l] <= z_r[i][l] + Z_W'(TURN_TAB[i]);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[CORDIC_STAGES-1]) begin
        cos_r[l] <= flip_r[CORDIC_STEPS][l] ? -x_r[CORDIC_STEPS][l] : x_r[CORDIC_STEPS][l];
        sin_r[l] <= flip_r[CORDIC_STEPS][l] ? -y_r[CORDIC_STEPS][l] : y_r[CORDIC_STEPS][l];
      end
    end

    assign cos_o[l] = cos_r[l];
    assign sin_o[l] = sin_r[l];
  end

  assign pass_o = pass_r[CORDIC_STAGES-1];

endmodule

[src/rap_rot.sv]
module rap_rot import rap_pkg::*; #(
  parameter int RW     = COORD_WIDTH_DEF + ROT_MARGIN,
  parameter int PASS_W = 1
) (
  input  logic                 clk,
  input  logic [1:0]           en,
  input  logic signed [RW-1:0] a_i,
  input  logic signed [RW-1:0] b_i,
  input  cs_t                  c_i,
  input  cs_t                  s_i,
  input  logic [PASS_W-1:0]    pass_i,
  output logic signed [RW-1:0] a_o,
  output logic signed [RW-1:0] b_o,
  output logic [PASS_W-1:0]    pass_o
);

  localparam int PW = RW + CS_W;
  localparam int SW = RW + CS_W + 1;
  localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (FRAC_BITS - 1);

  logic signed [PW-1:0] pp_r [4];
  logic [PASS_W-1:0]    pass1_r;
  logic signed [RW-1:0] a_r;
  logic signed [RW-1:0] b_r;
  logic [PASS_W-1:0]    pass2_r;
  logic signed [SW-1:0] rnd [4];
  logic signed [SW-1:0] a_nxt;
  logic signed [SW-1:0] b_nxt;

  // a' = a*c - b*s, b' = a*s + b*c
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_r[0] <= PW'(a_i) * PW'(c_i);
      pp_r[1] <= PW'(b_i) * PW'(s_i);
      pp_r[2] <= PW'(a_i) * PW'(s_i);
      pp_r[3] <= PW'(b_i) * PW'(c_i);
      pass1_r <= pass_i;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rnd[j] = (SW'(pp_r[j]) + RND_HALF) >>> FRAC_BITS;
    end
    a_nxt = rnd[0] - rnd[1];
    b_nxt = rnd[2] + rnd[3];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a_r     <= a_nxt[RW-1:0];
      b_r     <= b_nxt[RW-1:0];
      pass2_r <= pass1_r;
    end
  end

  assign a_o    = a_r;
  assign b_o    = b_r;
  assign pass_o = pass2_r;

endmodule
